@@ hdl/polygon_edge_intersection_unit_assert.svh @@
// Assertion helpers for the polygon edge intersection unit.
// They expect clk and arst_n in scope.
`ifndef POLYGON_EDGE_INTERSECTION_UNIT_ASSERT_SVH
`define POLYGON_EDGE_INTERSECTION_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define PEIU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define PEIU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/peiu_pkg.sv @@
`timescale 1ns / 1ps

package peiu_pkg;

	localparam int MAX_VERTS = 16;
	localparam int IDX_W     = $clog2(MAX_VERTS);
	localparam int CNT_W     = $clog2(MAX_VERTS + 1);

	localparam int COORD_W = 16;
	localparam int VERT_W  = 2 * COORD_W;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	typedef struct packed {
		logic                      operation;
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last;
	} req_t;

	typedef struct packed {
		logic hit;
		logic truncated;
	} res_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pt_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             rd_a_en;
		logic [IDX_W-1:0] rd_a_addr;
		logic             rd_b_en;
		logic [IDX_W-1:0] rd_b_addr;
		logic             cap_first;
		logic             cap_second;
		logic             shift_q;
		logic             finish;
		logic             check;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNT_W-1:0] count_a;
		logic [CNT_W-1:0] count_b;
		logic             edge_hit;
	} sts_t;

endpackage

@@ hdl/peiu_ram.sv @@
`timescale 1ns / 1ps

module peiu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hdl/peiu_dp.sv @@
`timescale 1ns / 1ps

module peiu_dp import peiu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output sts_t sts,
	output res_t result
);

	// list bookkeeping
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic             rst_a_q, rst_b_q;
	logic             ovf_a_q, ovf_b_q;
	logic [CNT_W-1:0] eff_a, eff_b;
	logic             room_a, room_b;
	logic             ld_a, ld_b;
	logic [VERT_W-1:0] wr_vert;
	logic [VERT_W-1:0] rd_a_data, rd_b_data;

	assign ld_a    = cmd.load & ~request.operation;
	assign ld_b    = cmd.load & request.operation;
	assign eff_a   = rst_a_q ? '0 : cnt_a_q;
	assign eff_b   = rst_b_q ? '0 : cnt_b_q;
	assign room_a  = eff_a < CNT_W'(MAX_VERTS);
	assign room_b  = eff_b < CNT_W'(MAX_VERTS);
	assign wr_vert = {request.vertex_x, request.vertex_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			rst_a_q <= 1'b1;
			rst_b_q <= 1'b1;
			ovf_a_q <= 1'b0;
			ovf_b_q <= 1'b0;
		end else begin
			if (ld_a) begin
				rst_a_q <= request.last;
				cnt_a_q <= room_a ? eff_a + 1'b1 : eff_a;
				ovf_a_q <= (ovf_a_q & ~rst_a_q) | ~room_a;
			end
			if (ld_b) begin
				rst_b_q <= request.last;
				cnt_b_q <= room_b ? eff_b + 1'b1 : eff_b;
				ovf_b_q <= (ovf_b_q & ~rst_b_q) | ~room_b;
			end
		end
	end

	peiu_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_store_a (
		.clk     (clk),
		.wr_en   (ld_a & room_a),
		.wr_addr (eff_a[IDX_W-1:0]),
		.wr_data (wr_vert),
		.rd_en   (cmd.rd_a_en),
		.rd_addr (cmd.rd_a_addr),
		.rd_data (rd_a_data)
	);

	peiu_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTS)) u_store_b (
		.clk     (clk),
		.wr_en   (ld_b & room_b),
		.wr_addr (eff_b[IDX_W-1:0]),
		.wr_data (wr_vert),
		.rd_en   (cmd.rd_b_en),
		.rd_addr (cmd.rd_b_addr),
		.rd_data (rd_b_data)
	);

	// edge end points: P0->P1 from A, Q0->Q1 from B
	pt_t p0_q, p1_q, q0_q, q1_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_first) begin
			p0_q <= pt_t'(rd_a_data);
			q0_q <= pt_t'(rd_b_data);
		end
		if (cmd.cap_second) begin
			p1_q <= pt_t'(rd_a_data);
			q1_q <= pt_t'(rd_b_data);
		end else if (cmd.shift_q) begin
			q0_q <= q1_q;
		end
	end

	logic signed [DIFF_W-1:0] pdx, pdy, qdx, qdy, ox, oy;

	assign pdx = DIFF_W'(p1_q.x) - DIFF_W'(p0_q.x);
	assign pdy = DIFF_W'(p1_q.y) - DIFF_W'(p0_q.y);
	assign qdx = DIFF_W'(q1_q.x) - DIFF_W'(q0_q.x);
	assign qdy = DIFF_W'(q1_q.y) - DIFF_W'(q0_q.y);
	assign ox  = DIFF_W'(p0_q.x) - DIFF_W'(q0_q.x);
	assign oy  = DIFF_W'(p0_q.y) - DIFF_W'(q0_q.y);

	// stage 1: six 17x17 products
	logic signed [PROD_W-1:0] m_den0_s1, m_den1_s1, m_r0_s1, m_r1_s1, m_s0_s1, m_s1_s1;

	always_ff @(posedge clk) begin
		m_den0_s1 <= pdx * qdy;
		m_den1_s1 <= pdy * qdx;
		m_r0_s1   <= oy * qdx;
		m_r1_s1   <= ox * qdy;
		m_s0_s1   <= oy * pdx;
		m_s1_s1   <= ox * pdy;
	end

	// stage 2: cross products
	logic signed [CROSS_W-1:0] den_s2, r_s2, s_s2;

	always_ff @(posedge clk) begin
		den_s2 <= CROSS_W'(m_den0_s1) - CROSS_W'(m_den1_s1);
		r_s2   <= CROSS_W'(m_r0_s1) - CROSS_W'(m_r1_s1);
		s_s2   <= CROSS_W'(m_s0_s1) - CROSS_W'(m_s1_s1);
	end

	// negative den mirrors the range: den <= r,s <= 0
	logic den_neg, den_zero, in_pos, in_neg;

	assign den_neg  = den_s2[CROSS_W-1];
	assign den_zero = (den_s2 == '0);
	assign in_pos   = ~r_s2[CROSS_W-1] & ~s_s2[CROSS_W-1] & (r_s2 <= den_s2) & (s_s2 <= den_s2);
	assign in_neg   = (r_s2[CROSS_W-1] | (r_s2 == '0)) & (s_s2[CROSS_W-1] | (s_s2 == '0))
		& (r_s2 >= den_s2) & (s_s2 >= den_s2);

	assign sts.edge_hit = ~den_zero & (den_neg ? in_neg : in_pos);
	assign sts.count_a  = cnt_a_q;
	assign sts.count_b  = cnt_b_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.hit       <= cmd.check & sts.edge_hit;
			result.truncated <= ovf_a_q | ovf_b_q;
		end
	end

endmodule

@@ hdl/peiu_ctrl.sv @@
`timescale 1ns / 1ps

module peiu_ctrl import peiu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EMPTY  = 3'd1;
	localparam logic [2:0] S_FETCH0 = 3'd2;
	localparam logic [2:0] S_FETCH1 = 3'd3;
	localparam logic [2:0] S_CAPT   = 3'd4;
	localparam logic [2:0] S_MUL    = 3'd5;
	localparam logic [2:0] S_SUB    = 3'd6;
	localparam logic [2:0] S_CMP    = 3'd7;

	logic [2:0]       state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
	logic             done_q, done_d;
	logic             accept;
	logic [CNT_W-1:0] i_nx, j_nx, j_nx2;
	logic [IDX_W-1:0] i_wrap, j_wrap, jn_wrap;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign accept = start & ~busy;

	// successor indices with wrap to vertex 0 closing the polygon
	assign i_nx    = CNT_W'(i_q) + 1'b1;
	assign j_nx    = CNT_W'(j_q) + 1'b1;
	assign j_nx2   = j_nx + 1'b1;
	assign i_wrap  = (i_nx < sts.count_a) ? i_nx[IDX_W-1:0] : '0;
	assign j_wrap  = (j_nx < sts.count_b) ? j_nx[IDX_W-1:0] : '0;
	assign jn_wrap = (j_nx2 < sts.count_b) ? j_nx2[IDX_W-1:0] : '0;

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		done_d   = 1'b0;
		cmd      = '0;
		cmd.load = accept;
		case (state_q)
			S_IDLE: begin
				if (accept && request.operation && request.last) begin
					i_d     = '0;
					j_d     = '0;
					state_d = (sts.count_a == '0) ? S_EMPTY : S_FETCH0;
				end
			end
			S_EMPTY: begin
				cmd.finish = 1'b1;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end
			S_FETCH0: begin
				cmd.rd_a_en   = 1'b1;
				cmd.rd_a_addr = i_q;
				cmd.rd_b_en   = 1'b1;
				cmd.rd_b_addr = '0;
				state_d       = S_FETCH1;
			end
			S_FETCH1: begin
				cmd.cap_first = 1'b1;
				cmd.rd_a_en   = 1'b1;
				cmd.rd_a_addr = i_wrap;
				cmd.rd_b_en   = 1'b1;
				cmd.rd_b_addr = j_wrap;
				state_d       = S_CAPT;
			end
			S_CAPT: begin
				cmd.cap_second = 1'b1;
				state_d        = S_MUL;
			end
			S_MUL: begin
				state_d = S_SUB;
			end
			S_SUB: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.edge_hit) begin
					cmd.finish = 1'b1;
					cmd.check  = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end else if (j_nx < sts.count_b) begin
					j_d           = j_nx[IDX_W-1:0];
					cmd.shift_q   = 1'b1;
					cmd.rd_b_en   = 1'b1;
					cmd.rd_b_addr = jn_wrap;
					state_d       = S_CAPT;
				end else if (i_nx < sts.count_a) begin
					i_d     = i_nx[IDX_W-1:0];
					j_d     = '0;
					state_d = S_FETCH0;
				end else begin
					cmd.finish = 1'b1;
					cmd.check  = 1'b1;
					done_d     = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			done_q  <= done_d;
		end
	end

endmodule

@@ hdl/polygon_edge_intersection_unit.sv @@
`timescale 1ns / 1ps

// Polygon edge intersection unit. Vertices arrive one request per cycle
// (start high while busy is low): operation picks polygon A or B, last
// closes that polygon's list, and the next vertex for it starts a fresh
// list. Each polygon holds MAX_VERTS vertices; later ones are dropped and
// reported through truncated. A request that closes polygon B raises busy
// and runs the all-pairs edge test; the receiver cannot stall, so the one
// result is on result for exactly one cycle with done high, and busy is
// already low in that cycle. The test walks all na*nb edge pairs of
// polygons with na and nb vertices and ends early on the first crossing;
// an empty polygon A answers without the edge test. The single edge-pair
// datapath works through one pair at a time: each pair takes one store
// read plus a multiply stage, a subtract stage and a compare, and each
// edge of A adds two store reads. Vertex requests that do not close B
// give no result and do not raise busy.
module polygon_edge_intersection_unit import peiu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output res_t result
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: walks edge i of A and edge j of B, drives store reads
	peiu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// vertex stores, list counters and the cross-product pipeline
	peiu_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

	`include "polygon_edge_intersection_unit_assert.svh"

	// the result cycle is already idle
	`PEIU_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
	// one result per test
	`PEIU_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held past one cycle")
	// closing B always launches a test
	`PEIU_ASSERT_NEXT(a_close_b_busy, start && !busy && request.operation && request.last,
		busy, "closing vertex of B did not start the test")

endmodule
